>>> src/hrp_pkg.sv
// Package for the hash radix partitioner: field widths, operation codes,
// hash constants and the packed beat types of the request and response channels.
// Depends on nothing; every other file imports it.
`default_nettype none

package hrp_pkg;

   localparam int MAX_PART_BITS = 8;
   localparam int INDEX_BITS    = 20;
   localparam int PAYLOAD_BITS  = 32;
   localparam int KEY_BITS      = 64;
   localparam int OP_BITS       = 2;
   localparam int CFG_BITS      = 4;

   localparam int DEPTH   = 1 << MAX_PART_BITS;
   localparam int CNT_W   = INDEX_BITS + 1;
   localparam int SCAN_W  = MAX_PART_BITS + 1;

   // Counters saturate at the record limit, two to the INDEX_BITS.
   localparam logic [CNT_W-1:0] REC_LIMIT = {1'b1, {INDEX_BITS{1'b0}}};

   localparam logic [CFG_BITS-1:0] PART_BITS_RESET = CFG_BITS'(1);
   localparam logic [CFG_BITS-1:0] PART_BITS_MAX   = CFG_BITS'(MAX_PART_BITS);

   localparam logic [31:0] FMIX_C1 = 32'h85eb_ca6b;
   localparam logic [31:0] FMIX_C2 = 32'hc2b2_ae35;

   localparam logic [OP_BITS-1:0] OP_CLEAR   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_COUNT   = 2'd1;
   localparam logic [OP_BITS-1:0] OP_SCAN    = 2'd2;
   localparam logic [OP_BITS-1:0] OP_SCATTER = 2'd3;

   typedef struct packed {
      logic [OP_BITS-1:0]      op;
      logic [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0] payload;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0]    dest_index;
      logic [MAX_PART_BITS-1:0] partition;
      logic [KEY_BITS-1:0]      out_key;
      logic [PAYLOAD_BITS-1:0]  out_payload;
   } rsp_type;

endpackage

`default_nettype wire

>>> src/hash_radix_partitioner_top.sv
// Top level of the hash radix partitioner: hash pipeline, counter memory with
// read-modify-write control, prefix scan sequencer and response register.
// Depends on hrp_pkg.
`default_nettype none

// The block hash-partitions one relation against a memory of 256 partition
// counters of 21 bits each. Every request beat carries an operation: clear
// zeroes all counters (a row of valid bits is dropped, and an entry that is not
// valid reads as zero); count hashes the key and bumps its partition's counter,
// saturating at the record limit; scan rewrites the first two-to-the-part_bits
// counters in place as exclusive prefix-sum start offsets; scatter hashes the
// key, returns the partition's cursor as the destination index on the response
// channel together with the key and payload, and advances the cursor (a scatter
// whose cursor has reached the record limit is dropped and gives no response
// beat). The partition id is the top part_bits bits of the Murmur3 fmix32 of
// the key's low word XOR its high word; part_bits is the single configuration
// register, 0 acting as 1 and values above 8 as 8, and it may be written only
// while the block is idle. The block works on one item at a time. A count or
// scatter goes through accept and first multiply, second multiply, memory read,
// and the write back, because the two hash multiplies and the memory read lie
// in series ahead of the update. A scatter waits further while an earlier
// response beat is still stalled in the response register. A scan goes through
// the accept step, then entry by entry the single read port fetches that entry
// while the single write port stores the start offset of the one before it,
// then a step writes back the last entry, and a last step returns to idle.
module hash_radix_partitioner_top (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  hrp_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output hrp_pkg::rsp_type                   rsp_data,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [hrp_pkg::CFG_BITS-1:0]       csr_data
);
   import hrp_pkg::*;

   // Sequencer state codes.
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL2 = 3'd1;
   localparam logic [2:0] ST_ADDR = 3'd2;
   localparam logic [2:0] ST_RMW  = 3'd3;
   localparam logic [2:0] ST_SCAN = 3'd4;

   logic [2:0]               state_ff, state_in;
   req_type                  item_ff, item_in;
   logic [31:0]              m1_ff, m1_in;
   logic [31:0]              m2_ff, m2_in;
   logic [MAX_PART_BITS-1:0] pid_ff, pid_in;
   logic [CFG_BITS-1:0]      part_bits_ff, part_bits_in;
   logic [DEPTH-1:0]         valid_ff, valid_in;
   logic [SCAN_W-1:0]        scan_rd_ff, scan_rd_in;
   logic [MAX_PART_BITS-1:0] scan_wr_ff, scan_wr_in;
   logic                     scan_pend_ff, scan_pend_in;
   logic [CNT_W-1:0]         running_ff, running_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   // Counter memory, one read and one write port, registered read data.
   logic [CNT_W-1:0]         mem [DEPTH];
   logic [CNT_W-1:0]         rd_data_ff;
   logic                     rd_vld_ff;
   logic                     mem_we;
   logic [MAX_PART_BITS-1:0] mem_waddr;
   logic [CNT_W-1:0]         mem_wdata;
   logic                     mem_re;
   logic [MAX_PART_BITS-1:0] mem_raddr;

   logic [31:0]              hx;
   logic [31:0]              h1;
   logic [31:0]              h2;
   logic [31:0]              h3;
   logic [CFG_BITS-1:0]      eff_bits;
   logic [MAX_PART_BITS-1:0] pid;
   logic [SCAN_W-1:0]        scan_n;
   logic [CNT_W-1:0]         cnt;
   logic [CNT_W:0]           sum;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Out-of-range part_bits values are clamped to the legal range.
   always_comb begin
      if (part_bits_ff == '0) begin
         eff_bits = CFG_BITS'(1);
      end else if (part_bits_ff > PART_BITS_MAX) begin
         eff_bits = PART_BITS_MAX;
      end else begin
         eff_bits = part_bits_ff;
      end
   end

   assign scan_n = SCAN_W'(1) << eff_bits;

   // fmix32 split over the m1 and m2 register stages, one multiply per register stage.
   assign hx  = req_data.key[31:0] ^ req_data.key[63:32];
   assign h1  = hx ^ (hx >> 16);
   assign h2  = m1_ff ^ (m1_ff >> 13);
   assign h3  = m2_ff ^ (m2_ff >> 16);
   assign pid = h3[31 -: MAX_PART_BITS] >> (PART_BITS_MAX - eff_bits);

   // A counter that was never written since the last clear reads as zero.
   assign cnt = rd_vld_ff ? rd_data_ff : '0;
   assign sum = {1'b0, running_ff} + {1'b0, cnt};

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      m1_in        = m1_ff;
      m2_in        = m2_ff;
      pid_in       = pid_ff;
      part_bits_in = part_bits_ff;
      valid_in     = valid_ff;
      scan_rd_in   = scan_rd_ff;
      scan_wr_in   = scan_wr_ff;
      scan_pend_in = scan_pend_ff;
      running_in   = running_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         part_bits_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
               m1_in   = h1 * FMIX_C1;
               unique case (req_data.op) inside
                  OP_CLEAR: begin
                     valid_in = '0;
                  end
                  OP_SCAN: begin
                     state_in     = ST_SCAN;
                     scan_rd_in   = '0;
                     scan_pend_in = 1'b0;
                     running_in   = '0;
                  end
                  OP_COUNT, OP_SCATTER: begin
                     state_in = ST_MUL2;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MUL2: begin
            m2_in    = h2 * FMIX_C2;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            mem_re    = 1'b1;
            mem_raddr = pid;
            pid_in    = pid;
            state_in  = ST_RMW;
         end
         ST_RMW: begin
            if (cnt >= REC_LIMIT) begin
               state_in = ST_IDLE;
            end else if (item_ff.op == OP_COUNT) begin
               mem_we    = 1'b1;
               mem_waddr = pid_ff;
               mem_wdata = cnt + CNT_W'(1);
               state_in  = ST_IDLE;
            end else if (!rsp_valid_ff || !rsp_stall) begin
               // Scatter: hold here until the response register is free.
               mem_we                  = 1'b1;
               mem_waddr               = pid_ff;
               mem_wdata               = cnt + CNT_W'(1);
               rsp_valid_in            = 1'b1;
               rsp_data_in.dest_index  = cnt[INDEX_BITS-1:0];
               rsp_data_in.partition   = pid_ff;
               rsp_data_in.out_key     = item_ff.key;
               rsp_data_in.out_payload = item_ff.payload;
               state_in                = ST_IDLE;
            end
         end
         ST_SCAN: begin
            // Read entry i while entry i-1 receives its start offset.
            if (scan_rd_ff < scan_n) begin
               mem_re       = 1'b1;
               mem_raddr    = scan_rd_ff[MAX_PART_BITS-1:0];
               scan_wr_in   = scan_rd_ff[MAX_PART_BITS-1:0];
               scan_rd_in   = scan_rd_ff + SCAN_W'(1);
               scan_pend_in = 1'b1;
            end else begin
               scan_pend_in = 1'b0;
               if (!scan_pend_ff) begin
                  state_in = ST_IDLE;
               end
            end
            if (scan_pend_ff) begin
               mem_we     = 1'b1;
               mem_waddr  = scan_wr_ff;
               mem_wdata  = running_ff;
               running_in = (sum > {1'b0, REC_LIMIT}) ? REC_LIMIT : sum[CNT_W-1:0];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (mem_we) begin
         valid_in[mem_waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         part_bits_ff <= PART_BITS_RESET;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         scan_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         part_bits_ff <= part_bits_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_pend_ff <= scan_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      m1_ff       <= m1_in;
      m2_ff       <= m2_in;
      pid_ff      <= pid_in;
      scan_rd_ff  <= scan_rd_in;
      scan_wr_ff  <= scan_wr_in;
      running_ff  <= running_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
         rd_vld_ff  <= valid_ff[mem_raddr];
      end
   end

   // The scan never writes the entry it is reading in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
      else $error("counter memory read and write collide on one entry");

   // No counter or cursor is ever written beyond the record limit.
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (mem_wdata <= REC_LIMIT))
      else $error("counter write exceeds the record limit");

   // The scan read pointer never runs past the scanned extent.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_rd_ff <= scan_n))
      else $error("scan pointer ran past the partition count");

   // A response beat is loaded only by the write back of a scatter.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !rsp_valid_ff) |-> (state_ff == ST_RMW && mem_we))
      else $error("response beat raised without a cursor update");

endmodule

`default_nettype wire

>>> test/tb_hash_radix_partitioner_top.sv
// Self-checking testbench for hash_radix_partitioner_top: directed partitioning cases,
// then random clear/count/scan/scatter passes under varied handshake idling.
// Depends on hrp_pkg and the RTL of the block; reads and writes no files.

module tb_hash_radix_partitioner_top;

   import hrp_pkg::*;

   // After the last response beat the block may still be busy with a scan of all 256
   // partitions, so we wait this long before a register write and at the end
   // of the run.
   localparam int SETTLE_CYCLES = DEPTH + 44;

   // The slowest legal run stays far below this, even with heavy stalls.
   localparam int unsigned CYCLE_LIMIT = 1_000_000;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CFG_BITS-1:0] csr_data  = '0;

   // Our own copy of the counter memory and of part_bits. Each entry is a histogram
   // bin during counting and a write cursor after a scan.
   logic [CNT_W-1:0]    cursor_model [DEPTH] = '{default: '0};
   logic [CFG_BITS-1:0] model_part_bits = PART_BITS_RESET;

   // Scattered records that the block still owes us, oldest first.
   rsp_type             expected_scatters [$];

   int unsigned         sender_idle_pct   = 0;
   int unsigned         receiver_idle_pct = 0;
   int                  rsp_hold_left     = 0;
   int unsigned         mismatch_count    = 0;
   int unsigned         cycle_count       = 0;

   hash_radix_partitioner_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Two time units per period: inputs move on the falling edge, and everything the
   // block drives is sampled on the rising edge.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------

   // A register value of zero behaves as one partition bit, and anything above the
   // maximum behaves as the maximum.
   function automatic int unsigned effective_bits(input logic [CFG_BITS-1:0] cfg);
      if (cfg == '0) return 1;
      if (cfg > PART_BITS_MAX) return MAX_PART_BITS;
      return 32'(cfg);
   endfunction

   // Fold the key to 32 bits, run the Murmur3 fmix32 finalizer, and keep the top bits.
   function automatic logic [MAX_PART_BITS-1:0] fmix_partition(input logic [KEY_BITS-1:0] key,
                                                               input logic [CFG_BITS-1:0] cfg);
      logic [31:0] h;
      int unsigned nbits;
      nbits = effective_bits(cfg);
      h = key[31:0] ^ key[63:32];
      h = h ^ (h >> 16);
      h = h * FMIX_C1;
      h = h ^ (h >> 13);
      h = h * FMIX_C2;
      h = h ^ (h >> 16);
      h = h >> (32 - nbits);
      return h[MAX_PART_BITS-1:0];
   endfunction

   // Apply one accepted request beat to the counter model and queue the response beat
   // that a scatter owes.
   function automatic void step_cursor_model(input req_type item);
      logic [CNT_W-1:0]         c;
      logic [MAX_PART_BITS-1:0] pid;
      int unsigned              running;
      int unsigned              n;
      rsp_type                  beat;
      case (item.op)
         OP_CLEAR: begin
            // Clear reaches every entry, whatever part_bits says.
            for (int i = 0; i < DEPTH; i++) cursor_model[i] = '0;
         end
         OP_COUNT: begin
            pid = fmix_partition(item.key, model_part_bits);
            if (cursor_model[pid] < REC_LIMIT) cursor_model[pid] = cursor_model[pid] + 1'b1;
         end
         OP_SCAN: begin
            // Exclusive prefix sum over the live partitions only; the running total
            // sticks at the record limit once it gets there.
            n = 1 << effective_bits(model_part_bits);
            running = 0;
            for (int i = 0; i < n; i++) begin
               c = cursor_model[i];
               cursor_model[i] = running[CNT_W-1:0];
               running = running + 32'(c);
               if (running > 32'(REC_LIMIT)) running = 32'(REC_LIMIT);
            end
         end
         OP_SCATTER: begin
            // An exhausted cursor swallows the record without a response beat.
            pid = fmix_partition(item.key, model_part_bits);
            c = cursor_model[pid];
            if (c < REC_LIMIT) begin
               cursor_model[pid] = c + 1'b1;
               beat.dest_index  = c[INDEX_BITS-1:0];
               beat.partition   = pid;
               beat.out_key     = item.key;
               beat.out_payload = item.payload;
               expected_scatters.push_back(beat);
            end
         end
      endcase
   endfunction

   function automatic logic [KEY_BITS-1:0] random_key();
      return {$urandom, $urandom};
   endfunction

   // Draw random keys until one lands in the wanted partition. At eight bits this takes
   // a few hundred tries on average, all in zero simulation time.
   function automatic logic [KEY_BITS-1:0] key_for_partition(input logic [MAX_PART_BITS-1:0] pid,
                                                             input logic [CFG_BITS-1:0] cfg);
      logic [KEY_BITS-1:0] k;
      k = random_key();
      while (fmix_partition(k, cfg) != pid) k = random_key();
      return k;
   endfunction

   // ---------------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------------

   // Offer one request beat, idling first at the current sender rate, and hold it until
   // the block takes it. Valid stays high on return, so a following call can present
   // the next beat on the very next falling edge without a bubble; anything else that
   // waits lowers valid first.
   task automatic send_item(input logic [OP_BITS-1:0]      op,
                            input logic [KEY_BITS-1:0]     key,
                            input logic [PAYLOAD_BITS-1:0] payload);
      req_type item;
      item.op      = op;
      item.key     = key;
      item.payload = payload;
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      step_cursor_model(item);
   endtask

   // Stop sending, wait for every owed response beat, then give a trailing scan time
   // to finish.
   task automatic settle_block();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_scatters.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The partition count may only change while the block is quiet.
   task automatic write_part_bits(input logic [CFG_BITS-1:0] value);
      settle_block();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      model_part_bits = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------------------

   // The receiver either serves a long hold-off requested by a test or stalls at random
   // at the current receiver rate.
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left = rsp_hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
   end

   // Every accepted response beat is matched against the oldest owed scatter.
   always @(posedge clock) begin : check_beat
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_scatters.size() == 0) begin
            $error("unexpected response beat: dest_index %0d, partition %0d",
                   rsp_data.dest_index, rsp_data.partition);
            mismatch_count++;
         end else begin
            want = expected_scatters.pop_front();
            if (rsp_data.dest_index !== want.dest_index) begin
               $error("dest_index: expected %0d, got %0d", want.dest_index, rsp_data.dest_index);
               mismatch_count++;
            end
            if (rsp_data.partition !== want.partition) begin
               $error("partition: expected %0d, got %0d", want.partition, rsp_data.partition);
               mismatch_count++;
            end
            if (rsp_data.out_key !== want.out_key) begin
               $error("out_key: expected %h, got %h", want.out_key, rsp_data.out_key);
               mismatch_count++;
            end
            if (rsp_data.out_payload !== want.out_payload) begin
               $error("out_payload: expected %h, got %h", want.out_payload, rsp_data.out_payload);
               mismatch_count++;
            end
         end
      end
   end

   // A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Straight out of reset, with one partition bit, a scatter uses the raw zero counts
   // as cursors. The key and payload extremes go through here.
   task automatic test_reset_defaults();
      send_item(OP_SCATTER, '0, '0);
      send_item(OP_SCATTER, '1, '1);
   endtask

   // Count, scan and scatter, the counts and scatters with alternating bit patterns in key and payload.
   task automatic test_ops_and_extremes();
      write_part_bits(PART_BITS_MAX);
      send_item(OP_COUNT, 64'h5555_5555_5555_5555, 32'haaaa_aaaa);
      send_item(OP_COUNT, 64'haaaa_aaaa_aaaa_aaaa, 32'h5555_5555);
      send_item(OP_SCAN, random_key(), $urandom);
      send_item(OP_SCATTER, 64'haaaa_aaaa_aaaa_aaaa, 32'h5555_5555);
      send_item(OP_SCATTER, 64'h5555_5555_5555_5555, 32'haaaa_aaaa);
   endtask

   // Zero behaves as one bit; every value above eight behaves as eight.
   task automatic test_part_bits_limits();
      write_part_bits('0);
      send_item(OP_SCATTER, random_key(), $urandom);
      write_part_bits('1);
      send_item(OP_SCATTER, random_key(), $urandom);
      write_part_bits(PART_BITS_MAX + 1'b1);
      send_item(OP_SCATTER, random_key(), $urandom);
   endtask

   // A narrow scan leaves the upper partitions alone, while a clear wipes all of them.
   task automatic test_scan_and_clear_extent();
      logic [KEY_BITS-1:0] high_key;
      high_key = key_for_partition(8'd200, PART_BITS_MAX);
      write_part_bits(PART_BITS_MAX);
      send_item(OP_CLEAR, random_key(), $urandom);
      send_item(OP_COUNT, high_key, $urandom);
      write_part_bits(PART_BITS_RESET);
      send_item(OP_SCAN, random_key(), $urandom);
      write_part_bits(PART_BITS_MAX);
      send_item(OP_SCATTER, high_key, $urandom);
      write_part_bits(PART_BITS_RESET);
      send_item(OP_CLEAR, random_key(), $urandom);
      write_part_bits(PART_BITS_MAX);
      send_item(OP_SCATTER, high_key, $urandom);
   endtask

   // One count in partition 0 followed by four scans grows the cursors like binomial
   // coefficients: partition 160 ends up between half the record limit and the full
   // limit, and the upper partitions saturate. Counting into a saturated partition
   // leaves it there, and a scatter into it is dropped.
   task automatic test_counter_saturation();
      logic [KEY_BITS-1:0] full_key;
      full_key = key_for_partition(8'd255, PART_BITS_MAX);
      send_item(OP_CLEAR, random_key(), $urandom);
      send_item(OP_COUNT, key_for_partition(8'd0, PART_BITS_MAX), $urandom);
      repeat (4) send_item(OP_SCAN, random_key(), $urandom);
      send_item(OP_SCATTER, key_for_partition(8'd160, PART_BITS_MAX), $urandom);
      send_item(OP_COUNT, full_key, $urandom);
      send_item(OP_SCATTER, full_key, $urandom);
   endtask

   // The receiver holds off for a long stretch while scatters keep coming, so the
   // response register fills and the block stalls its request side. Afterwards the
   // sender pauses until everything has drained.
   task automatic test_output_backpressure();
      send_item(OP_CLEAR, random_key(), $urandom);
      rsp_hold_left = 400;
      repeat (40) send_item(OP_SCATTER, random_key(), $urandom);
      settle_block();
   endtask

   // Mostly complete partitioning passes with random content: clear, a burst of counts
   // with some repeated keys, a scan, then the same records scattered in random order.
   // Some passes miss their clear or scan, some scatters carry a stray key, and a share
   // of the iterations are lone random operations or a change of part_bits.
   task automatic run_partition_batches(input int unsigned item_budget);
      logic [KEY_BITS-1:0] pending [$];
      logic [KEY_BITS-1:0] k;
      int unsigned         sent;
      int unsigned         n_records;
      int unsigned         pick;
      sent = 0;
      while (sent < item_budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            write_part_bits(CFG_BITS'($urandom_range(0, 15)));
         end else if (pick < 80) begin
            pending.delete();
            n_records = $urandom_range(1, 24);
            if ($urandom_range(0, 9) != 0) begin
               send_item(OP_CLEAR, random_key(), $urandom);
               sent++;
            end
            for (int i = 0; i < n_records; i++) begin
               if (pending.size() != 0 && $urandom_range(0, 3) == 0)
                  k = pending[$urandom_range(0, pending.size() - 1)];
               else
                  k = random_key();
               pending.push_back(k);
               send_item(OP_COUNT, k, $urandom);
               sent++;
            end
            if ($urandom_range(0, 9) != 0) begin
               send_item(OP_SCAN, random_key(), $urandom);
               sent++;
            end
            while (pending.size() != 0) begin
               pick = $urandom_range(0, pending.size() - 1);
               k = pending[pick];
               pending.delete(pick);
               if ($urandom_range(0, 7) == 0) k = random_key();
               send_item(OP_SCATTER, k, $urandom);
               sent++;
            end
         end else begin
            send_item(OP_BITS'($urandom_range(0, 3)), random_key(), $urandom);
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Sequence of the run
   // ---------------------------------------------------------------------------------

   initial begin
      // Reset is held from the start and released on a falling edge.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // First phase: the sender idles a little, the receiver a lot.
      sender_idle_pct   = 35;
      receiver_idle_pct = 86;
      test_reset_defaults();
      test_ops_and_extremes();
      test_part_bits_limits();
      test_scan_and_clear_extent();
      test_counter_saturation();
      run_partition_batches(480);

      // Second phase: the other way round.
      settle_block();
      sender_idle_pct   = 86;
      receiver_idle_pct = 35;
      run_partition_batches(480);

      // Third phase: both sides run flat out, apart from the forced hold-off.
      settle_block();
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      test_output_backpressure();
      run_partition_batches(480);

      settle_block();
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
